/* rtl/core/text_console_writer_defines.svh */
// ---------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property shorthands for the console writer checks.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tcw_pkg.sv */
// ---------------------------------------------------------------------------
// Text console writer package
// Grid geometry, field widths, command codes and the microprogram.
// ---------------------------------------------------------------------------
package tcw_pkg;

   // grid geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   // field widths
   localparam int COL_W  = 7;
   localparam int ROW_W  = 6;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int LIN_W  = ROW_W + COL_W + 1;

   // characters
   localparam logic [CHAR_W-1:0] CH_ERROR   = 8'h45;
   localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

   // command codes
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // register indexes and reset values
   localparam logic CSR_DEFAULT_ATTR = 1'b0;
   localparam logic CSR_ERROR_ATTR   = 1'b1;
   localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
   localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

   // sequencing conditions
   localparam logic [2:0] COND_NEXT       = 3'd0;
   localparam logic [2:0] COND_JUMP       = 3'd1;
   localparam logic [2:0] COND_DISPATCH   = 3'd2;
   localparam logic [2:0] COND_WAIT_START = 3'd3;
   localparam logic [2:0] COND_WAIT_FREE  = 3'd4;
   localparam logic [2:0] COND_WRAP       = 3'd5;
   localparam logic [2:0] COND_NOT_LAST   = 3'd6;

   // address register operations
   localparam logic [1:0] AOP_HOLD   = 2'd0;
   localparam logic [1:0] AOP_ZERO   = 2'd1;
   localparam logic [1:0] AOP_TARGET = 2'd2;
   localparam logic [1:0] AOP_INC    = 2'd3;

   // cell store write operations
   localparam logic [2:0] WOP_NONE  = 3'd0;
   localparam logic [2:0] WOP_ZERO  = 3'd1;
   localparam logic [2:0] WOP_CHAR  = 3'd2;
   localparam logic [2:0] WOP_ERROR = 3'd3;
   localparam logic [2:0] WOP_BLANK = 3'd4;
   localparam logic [2:0] WOP_MOVE  = 3'd5;

   // cell store read operations
   localparam logic [1:0] ROP_NONE = 2'd0;
   localparam logic [1:0] ROP_ADDR = 2'd1;
   localparam logic [1:0] ROP_SRC  = 2'd2;

   // cursor operations
   localparam logic [1:0] COP_HOLD    = 2'd0;
   localparam logic [1:0] COP_ADVANCE = 2'd1;
   localparam logic [1:0] COP_HOME    = 2'd2;

   // loop limits
   localparam logic LIM_ALL  = 1'b0;
   localparam logic LIM_MOVE = 1'b1;

   // command classes for the dispatch jump
   localparam logic [2:0] CLS_PUT     = 3'd0;
   localparam logic [2:0] CLS_BAD_PUT = 3'd1;
   localparam logic [2:0] CLS_READ    = 3'd2;
   localparam logic [2:0] CLS_CLEAR   = 3'd3;
   localparam logic [2:0] CLS_RESP    = 3'd4;

   // microprogram addresses
   localparam int UPC_W = 4;
   localparam logic [UPC_W-1:0] UA_INIT     = 4'd0;
   localparam logic [UPC_W-1:0] UA_IDLE     = 4'd1;
   localparam logic [UPC_W-1:0] UA_DECODE   = 4'd2;
   localparam logic [UPC_W-1:0] UA_PUT      = 4'd3;
   localparam logic [UPC_W-1:0] UA_RESP     = 4'd4;
   localparam logic [UPC_W-1:0] UA_BAD_PUT  = 4'd5;
   localparam logic [UPC_W-1:0] UA_READ     = 4'd6;
   localparam logic [UPC_W-1:0] UA_CAPTURE  = 4'd7;
   localparam logic [UPC_W-1:0] UA_CLEAR    = 4'd8;
   localparam logic [UPC_W-1:0] UA_CLR_LOOP = 4'd9;
   localparam logic [UPC_W-1:0] UA_CLR_DONE = 4'd10;
   localparam logic [UPC_W-1:0] UA_SCROLL   = 4'd11;
   localparam logic [UPC_W-1:0] UA_MV_RD    = 4'd12;
   localparam logic [UPC_W-1:0] UA_MV_WR    = 4'd13;
   localparam logic [UPC_W-1:0] UA_BLK_LOOP = 4'd14;
   localparam logic [UPC_W-1:0] UA_BLK_DONE = 4'd15;

   // one control word
   typedef struct packed {
      logic [2:0]       cond;
      logic [UPC_W-1:0] target;
      logic [1:0]       addr_op;
      logic [2:0]       wr_op;
      logic [1:0]       rd_op;
      logic [1:0]       cur_op;
      logic             lim;
      logic             idle;
      logic             decode;
      logic             capture;
      logic             respond;
   } uword_type;

   // datapath conditions back to the sequencer
   typedef struct packed {
      logic       start;
      logic       wrap;
      logic       last;
      logic       out_free;
      logic [2:0] cls;
   } status_type;

   // microprogram store
   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] pc);
      uword_type w;
      w = '0;
      unique case (pc)
         UA_INIT: begin
            // zero the whole store after reset
            w.wr_op   = WOP_ZERO;
            w.addr_op = AOP_INC;
            w.lim     = LIM_ALL;
            w.cond    = COND_NOT_LAST;
            w.target  = UA_INIT;
         end
         UA_IDLE: begin
            w.idle = 1'b1;
            w.cond = COND_WAIT_START;
         end
         UA_DECODE: begin
            w.decode  = 1'b1;
            w.addr_op = AOP_TARGET;
            w.cond    = COND_DISPATCH;
         end
         UA_PUT: begin
            w.wr_op  = WOP_CHAR;
            w.cur_op = COP_ADVANCE;
            w.cond   = COND_WRAP;
            w.target = UA_SCROLL;
         end
         UA_RESP: begin
            w.respond = 1'b1;
            w.cond    = COND_WAIT_FREE;
            w.target  = UA_IDLE;
         end
         UA_BAD_PUT: begin
            w.wr_op  = WOP_ERROR;
            w.cond   = COND_JUMP;
            w.target = UA_RESP;
         end
         UA_READ: begin
            w.rd_op = ROP_ADDR;
            w.cond  = COND_NEXT;
         end
         UA_CAPTURE: begin
            w.capture = 1'b1;
            w.cond    = COND_JUMP;
            w.target  = UA_RESP;
         end
         UA_CLEAR: begin
            w.addr_op = AOP_ZERO;
            w.cur_op  = COP_HOME;
            w.cond    = COND_NEXT;
         end
         UA_CLR_LOOP: begin
            w.wr_op   = WOP_BLANK;
            w.addr_op = AOP_INC;
            w.lim     = LIM_ALL;
            w.cond    = COND_NOT_LAST;
            w.target  = UA_CLR_LOOP;
         end
         UA_CLR_DONE: begin
            w.cond   = COND_JUMP;
            w.target = UA_RESP;
         end
         UA_SCROLL: begin
            w.addr_op = AOP_ZERO;
            w.cond    = COND_NEXT;
         end
         UA_MV_RD: begin
            // fetch the cell one row below
            w.rd_op = ROP_SRC;
            w.cond  = COND_NEXT;
         end
         UA_MV_WR: begin
            w.wr_op   = WOP_MOVE;
            w.addr_op = AOP_INC;
            w.lim     = LIM_MOVE;
            w.cond    = COND_NOT_LAST;
            w.target  = UA_MV_RD;
         end
         UA_BLK_LOOP: begin
            w.wr_op   = WOP_BLANK;
            w.addr_op = AOP_INC;
            w.lim     = LIM_ALL;
            w.cond    = COND_NOT_LAST;
            w.target  = UA_BLK_LOOP;
         end
         UA_BLK_DONE: begin
            w.cond   = COND_JUMP;
            w.target = UA_RESP;
         end
         default: begin
            w.cond   = COND_JUMP;
            w.target = UA_IDLE;
         end
      endcase
      return w;
   endfunction

   // dispatch map from command class to routine entry
   function automatic logic [UPC_W-1:0] dispatch_target(input logic [2:0] cls);
      logic [UPC_W-1:0] t;
      unique case (cls)
         CLS_PUT:     t = UA_PUT;
         CLS_BAD_PUT: t = UA_BAD_PUT;
         CLS_READ:    t = UA_READ;
         CLS_CLEAR:   t = UA_CLEAR;
         default:     t = UA_RESP;
      endcase
      return t;
   endfunction

endpackage

/* rtl/core/tcw_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tcw_sequencer.sv */
// ---------------------------------------------------------------------------
// Text console writer sequencer
// Step counter, microprogram lookup and conditional next-step selection.
// ---------------------------------------------------------------------------
module tcw_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::status_type   status,
   output tcw_pkg::uword_type    ctrl
);
   import tcw_pkg::*;

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic [UPC_W-1:0] upc_next;
   uword_type        word;

   // current control word
   assign word     = ucode_rom(upc_ff);
   assign ctrl     = word;
   assign upc_next = upc_ff + UPC_W'(1);

   // next step
   always_comb begin
      unique case (word.cond)
         COND_NEXT:       upc_in = upc_next;
         COND_JUMP:       upc_in = word.target;
         COND_DISPATCH:   upc_in = dispatch_target(status.cls);
         COND_WAIT_START: upc_in = status.start ? upc_next : upc_ff;
         COND_WAIT_FREE:  upc_in = status.out_free ? word.target : upc_ff;
         COND_WRAP:       upc_in = status.wrap ? word.target : upc_next;
         COND_NOT_LAST:   upc_in = status.last ? upc_next : word.target;
         default:         upc_in = UA_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_INIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* rtl/core/tcw_datapath.sv */
// ---------------------------------------------------------------------------
// Text console writer datapath
// Request and cursor registers, cell address unit, cell store, result register.
// ---------------------------------------------------------------------------
module tcw_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::uword_type    ctrl,
   output tcw_pkg::status_type   status,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata
);
   import tcw_pkg::*;

   // configuration
   logic [ATTR_W-1:0] def_attr_ff, def_attr_in;
   logic [ATTR_W-1:0] err_attr_ff, err_attr_in;

   // latched request
   logic [1:0]        op_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic              usepos_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;

   // target, address and cursor
   logic [COL_W-1:0]  tgt_col_ff, tgt_col_in;
   logic [ROW_W-1:0]  tgt_row_ff, tgt_row_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;

   // result fields
   logic              bad_ff, bad_in;
   logic [CHAR_W-1:0] rd_char_ff, rd_char_in;
   logic [ATTR_W-1:0] rd_attr_ff, rd_attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic              start;
   logic              out_free;
   logic [COL_W-1:0]  sel_col;
   logic [ROW_W-1:0]  sel_row;
   logic [LIN_W-1:0]  lin;
   logic              oob;
   logic [2:0]        cls;
   logic              nl;
   logic [COL_W:0]    col_p1;
   logic              col_wrap;
   logic [ROW_W:0]    adv_row_full;
   logic              wrap;
   logic [COL_W-1:0]  adv_col;
   logic [ROW_W-1:0]  adv_row;
   logic [ATTR_W-1:0] attr_eff;
   logic [ADDR_W-1:0] limit;

   // cell store ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   // handshakes
   assign req_tready = ctrl.idle;
   assign start      = req_tvalid && ctrl.idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // register writes
   always_comb begin
      def_attr_in = def_attr_ff;
      err_attr_in = err_attr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEFAULT_ATTR: def_attr_in = csr_wdata;
            default:          err_attr_in = csr_wdata;
         endcase
      end
   end

   // target selection and linear cell address
   assign sel_col = usepos_ff ? col_ff : cur_col_ff;
   assign sel_row = usepos_ff ? row_ff : cur_row_ff;
   assign lin     = LIN_W'(sel_row) * LIN_W'(COLUMNS) + LIN_W'(sel_col);
   assign oob     = usepos_ff && (({1'b0, col_ff} >= (COL_W+1)'(COLUMNS)) ||
                                  ({1'b0, row_ff} >= (ROW_W+1)'(ROWS)));

   // command class for the dispatch jump
   always_comb begin
      unique case (op_ff)
         OP_PUT:   cls = oob ? CLS_BAD_PUT : CLS_PUT;
         OP_READ:  cls = oob ? CLS_RESP : CLS_READ;
         OP_CLEAR: cls = CLS_CLEAR;
         default:  cls = CLS_RESP;
      endcase
   end

   // cursor advance: next cell or start of next row, clamp on scroll
   assign nl           = (ch_ff == CH_NEWLINE);
   assign col_p1       = {1'b0, tgt_col_ff} + (COL_W+1)'(1);
   assign col_wrap     = nl || (col_p1 == (COL_W+1)'(COLUMNS));
   assign adv_col      = col_wrap ? '0 : col_p1[COL_W-1:0];
   assign adv_row_full = {1'b0, tgt_row_ff} + (ROW_W+1)'(col_wrap);
   assign wrap         = (adv_row_full == (ROW_W+1)'(ROWS));
   assign adv_row      = wrap ? ROW_W'(ROWS - 1) : adv_row_full[ROW_W-1:0];

   assign attr_eff = (attr_ff == '0) ? def_attr_ff : attr_ff;
   assign limit    = (ctrl.lim == LIM_MOVE) ? ADDR_W'(CELLS - COLUMNS - 1)
                                            : ADDR_W'(CELLS - 1);

   assign status.start    = start;
   assign status.wrap     = wrap;
   assign status.last     = (addr_ff == limit);
   assign status.out_free = out_free;
   assign status.cls      = cls;

   // address register
   always_comb begin
      unique case (ctrl.addr_op)
         AOP_ZERO:   addr_in = '0;
         AOP_TARGET: addr_in = lin[ADDR_W-1:0];
         AOP_INC:    addr_in = addr_ff + ADDR_W'(1);
         default:    addr_in = addr_ff;
      endcase
   end

   // cell store write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = rd_data;
      unique case (ctrl.wr_op)
         WOP_ZERO: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         WOP_CHAR: begin
            wr_en   = !nl;
            wr_data = {attr_eff, ch_ff};
         end
         WOP_ERROR: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(CELLS - 1);
            wr_data = {err_attr_ff, CH_ERROR};
         end
         WOP_BLANK: begin
            wr_en   = 1'b1;
            wr_data = {def_attr_ff, CH_BLANK};
         end
         WOP_MOVE: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // cell store read port
   assign rd_en   = (ctrl.rd_op != ROP_NONE);
   assign rd_addr = (ctrl.rd_op == ROP_SRC) ? addr_ff + ADDR_W'(COLUMNS) : addr_ff;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // target, cursor and result fields
   always_comb begin
      tgt_col_in = tgt_col_ff;
      tgt_row_in = tgt_row_ff;
      bad_in     = bad_ff;
      rd_char_in = rd_char_ff;
      rd_attr_in = rd_attr_ff;
      if (start) begin
         rd_char_in = '0;
         rd_attr_in = '0;
      end
      if (ctrl.decode) begin
         tgt_col_in = sel_col;
         tgt_row_in = sel_row;
         bad_in     = oob && ((op_ff == OP_PUT) || (op_ff == OP_READ));
      end
      if (ctrl.capture) begin
         rd_char_in = rd_data[CHAR_W-1:0];
         rd_attr_in = rd_data[CELL_W-1:CHAR_W];
      end
   end

   always_comb begin
      unique case (ctrl.cur_op)
         COP_ADVANCE: begin
            cur_col_in = adv_col;
            cur_row_in = adv_row;
         end
         COP_HOME: begin
            cur_col_in = '0;
            cur_row_in = '0;
         end
         default: begin
            cur_col_in = cur_col_ff;
            cur_row_in = cur_row_ff;
         end
      endcase
   end

   // result register: loads while the slot is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.respond && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, rd_attr_ff, rd_char_ff, cur_row_ff, cur_col_ff};
         rsp_bad_in   = bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         def_attr_ff  <= DEFAULT_ATTR_RST;
         err_attr_ff  <= ERROR_ATTR_RST;
         addr_ff      <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         def_attr_ff  <= def_attr_in;
         err_attr_ff  <= err_attr_in;
         addr_ff      <= addr_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start) begin
         op_ff     <= req_tuser[1:0];
         usepos_ff <= req_tuser[2];
         ch_ff     <= req_tdata[7:0];
         attr_ff   <= req_tdata[15:8];
         col_ff    <= req_tdata[22:16];
         row_ff    <= req_tdata[28:23];
      end
      tgt_col_ff  <= tgt_col_in;
      tgt_row_ff  <= tgt_row_in;
      bad_ff      <= bad_in;
      rd_char_ff  <= rd_char_in;
      rd_attr_ff  <= rd_attr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

endmodule

/* rtl/core/text_console_writer.sv */
// ---------------------------------------------------------------------------
// Text console writer
// Character-cell console engine run by a microprogrammed sequencer.
// ---------------------------------------------------------------------------
//  channel | ports               | carries
//  req     | req_tvalid/tready   | tdata: char_code, attr, col, row; tuser: opcode, use_position
//  rsp     | rsp_tvalid/tready   | tdata: cursor_col, cursor_row, cell_char, cell_attr;
//          |                     | tuser: bad_position
//  csr     | csr_valid/ready     | csr_index, csr_wdata (0 default_attribute, 1 error_attribute)
//
//  Put and bad put run idle, decode, execute, result load; a bad read and ignored commands
//  skip execute, a read executes as fetch then capture. The cell store has one write port,
//  so a clear blanks cell by cell and a scroll reads and writes each cell one row up, then
//  blanks the last row. After reset a clearing pass zeroes the store; req_tready stays low.
//  The result register lets the next transfer in while a result waits on rsp_tready.
// ---------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // char_code[7:0], attr[15:8], col[22:16], row[28:23]
   input  logic [2:0]  req_tuser,   // opcode[1:0], use_position[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_col[6:0], cursor_row[12:7], cell_char[20:13],
                                    // cell_attr[28:21]
   output logic        rsp_tuser,   // bad_position[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import tcw_pkg::*;

   uword_type  ctrl;
   status_type status;
   logic       cursor_on_grid;
   logic       cell_is_zero;

   tcw_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   tcw_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // result field checks
   assign cursor_on_grid = (rsp_tdata[6:0] < 7'(COLUMNS)) && (rsp_tdata[12:7] < 6'(ROWS));
   assign cell_is_zero   = (rsp_tdata[28:13] == 16'd0);

   // one request in flight at a time
   `TCW_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "request while busy")

   // reported cursor always lies on the grid
   `TCW_ASSERT_NOW(a_cursor_on_grid, rsp_tvalid, cursor_on_grid, "cursor off grid")

   // a bad position never reports cell contents
   `TCW_ASSERT_NOW(a_bad_no_cell, rsp_tvalid && rsp_tuser, cell_is_zero, "cell data on bad read")

endmodule
